>>> hw/rtl/mlfq_pkg.sv
// Shared types and constants of the feedback scheduler queues.
// Used by the FIFO, the heap level cell and the top level; no dependencies.
package mlfq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned TICK_BITS_DEF   = 32;

  localparam logic [3:0] TICKS_BOOST = 4'd4;

  typedef enum logic [1:0] {
    OP_FETCH = 2'd0,
    OP_PUSH  = 2'd1,
    OP_SIFT  = 2'd2
  } op_e;

  typedef struct packed {
    logic [5:0] pid;
    logic [3:0] ticks;
    logic [3:0] pri;
  } fifo_rec_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic tkw;
  } fifo_ctl_t;

endpackage

>>> hw/rtl/mlfq_scheduler_queues.sv
// Three-level feedback scheduler queues: two FIFO levels and a heap level
// built as a chain of level cells. Depends on mlfq_pkg, mlfq_fifo, mlfq_cell.
// A heap operation passes down the chain of level cells; a heap pop takes up
// to three chain passes. Boost sweeps level 0, moves each level 1 entry with
// a read and a write, and does one pop per heap entry. One beat is worked on
// at a time. Reset clears the control state and counts, not stored records.
module mlfq_scheduler_queues
  import mlfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TICK_BITS   = TICK_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // proc_id, level, ticks_left, priority_req, now_tick
  input  logic [47:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_proc_id, out_level, out_ticks_left, out_priority
  output logic [15:0] m_axis_tdata,
  // status, clear_tick
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned L  = PW;
  localparam int unsigned LW = $clog2(L);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = PW;
  localparam int unsigned RW = 14 + TICK_BITS;
  localparam int unsigned TW = 1 + 2 + RW + PW + LW + PW + 1;
  localparam int unsigned UW = 1 + PW + RW;
  localparam logic [3:0]  QUANTUM_BASE = 4'd4;
  localparam logic [3:0]  QUANTUM_TOP  = 4'd8;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_BOOST = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_EXEC  = 12'b0000_0000_0010,
    S_FRD   = 12'b0000_0000_0100,
    S_HWAIT = 12'b0000_0000_1000,
    S_HROOT = 12'b0000_0001_0000,
    S_HLAST = 12'b0000_0010_0000,
    S_HSIFT = 12'b0000_0100_0000,
    S_HFIN  = 12'b0000_1000_0000,
    S_SWEEP = 12'b0001_0000_0000,
    S_B1RD  = 12'b0010_0000_0000,
    S_B1WR  = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic [5:0]           pid;
    logic [3:0]           ticks;
    logic [3:0]           pri;
    logic [TICK_BITS-1:0] tk;
  } rec_t;

  typedef struct packed {
    logic          vld;
    op_e           op;
    rec_t          carry;
    logic [PW-1:0] pos;
    logic [LW-1:0] lvl;
    logic [PW-1:0] cnt;
    logic          ins;
  } tok_t;

  typedef struct packed {
    logic          vld;
    logic [PW-1:0] pos;
    rec_t          rec;
  } upw_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] pid;
    logic [1:0] lvl;
    logic [3:0] ticks;
    logic [3:0] pri;
    logic       clr;
  } res_t;

  state_e        state_q, state_d;
  req_e          req_q, req_d, in_req;
  logic [1:0]    lv_q, lv_d, lv_sat, en_lv;
  rec_t          rec_q, rec_d, pop_rec_q, pop_rec_d, resp;
  logic [CW-1:0] hc_q, hc_d, n_q, n_d;
  logic          lost_q, lost_d;
  res_t          res_q, res_d;
  tok_t          tok0_q, tok0_d;
  logic          m_valid_q, load;
  logic [15:0]   m_data_q;
  logic [2:0]    m_user_q;
  logic [3:0]    en_ticks, en_pri;
  logic [63:0]   now64;

  logic [TW-1:0] tok      [L+1];
  logic [UW-1:0] upw      [L+1];
  logic [RW-1:0] resp_vec [L];
  logic [L-1:0]  done_vec;
  logic          any_done;
  tok_t          tok_last;
  upw_t          upw_root, upw_fb;

  fifo_ctl_t     f_ctl [2];
  fifo_rec_t     f_wr  [2];
  fifo_rec_t     f_rd  [2];
  logic [CW-1:0] f_cnt [2];

  function automatic logic [LW-1:0] flog2(logic [PW-1:0] x);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < int'(PW); i++) begin
      if (x[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] dec_sat(logic [3:0] t);
    return (t == 4'd0) ? 4'd0 : t - 4'd1;
  endfunction

  for (genvar q = 0; q < 2; q++) begin : g_fifo
    mlfq_fifo #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_fifo (
      .clk_i,
      .rst_ni,
      .ctl_i (f_ctl[q]),
      .wr_i  (f_wr[q]),
      .off_i (n_q[AW-1:0]),
      .rd_o  (f_rd[q]),
      .cnt_o (f_cnt[q])
    );
  end

  // A sift that moves the carried record into the last heap level comes back
  // here and is written into that level.
  always_comb begin
    upw_fb     = '0;
    upw_fb.vld = tok_last.vld;
    upw_fb.pos = tok_last.pos;
    upw_fb.rec = tok_last.carry;
  end

  assign tok[0] = tok0_q;
  assign upw[L] = upw_fb;

  for (genvar k = 0; k < int'(L); k++) begin : g_cell
    mlfq_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TICK_BITS  (TICK_BITS),
      .K          (k)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .upw_i  (upw[k+1]),
      .upw_o  (upw[k]),
      .done_o (done_vec[k]),
      .resp_o (resp_vec[k])
    );
  end

  assign tok_last = tok[L];
  assign upw_root = upw[0];
  assign any_done = (|done_vec) | tok_last.vld;

  always_comb begin
    resp = '0;
    for (int k = 0; k < int'(L); k++) begin
      resp = resp | resp_vec[k];
    end
  end

  // Enqueue record with demotion applied.
  always_comb begin
    in_req   = req_e'(s_axis_tuser);
    now64    = {32'd0, s_axis_tdata[47:16]};
    lv_sat   = (s_axis_tdata[7:6] == 2'd3) ? 2'd2 : s_axis_tdata[7:6];
    en_lv    = lv_sat;
    en_ticks = s_axis_tdata[11:8];
    en_pri   = s_axis_tdata[15:12];
    if (s_axis_tdata[11:8] == 4'd0) begin
      if (lv_sat != 2'd2) begin
        en_lv    = lv_sat + 2'd1;
        en_ticks = 4'({en_lv, 1'b0}) + QUANTUM_BASE;
      end else begin
        en_ticks = QUANTUM_TOP;
        en_pri   = (en_pri == 4'd0) ? 4'd0 : en_pri - 4'd1;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign load          = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    lv_d      = lv_q;
    rec_d     = rec_q;
    pop_rec_d = pop_rec_q;
    hc_d      = hc_q;
    n_d       = n_q;
    lost_d    = lost_q;
    res_d     = res_q;
    tok0_d    = '0;
    f_ctl[0]  = '0;
    f_ctl[1]  = '0;
    f_wr[0]   = '0;
    f_wr[1]   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d     = in_req;
          lv_d      = (in_req == REQ_ENQ) ? en_lv : lv_sat;
          rec_d.pid = s_axis_tdata[5:0];
          rec_d.ticks = en_ticks;
          rec_d.pri = en_pri;
          rec_d.tk  = now64[TICK_BITS-1:0];
          lost_d    = 1'b0;
          n_d       = '0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_EMIT;
        case (req_q)
          REQ_ENQ: begin
            res_d.status = ST_OK;
            res_d.pid    = rec_q.pid;
            res_d.lvl    = lv_q;
            res_d.ticks  = rec_q.ticks;
            res_d.pri    = rec_q.pri;
            if (lv_q != 2'd2) begin
              if (f_cnt[lv_q[0]] == CW'(QUEUE_DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                f_ctl[lv_q[0]].push = 1'b1;
                f_wr[lv_q[0]] = '{pid: rec_q.pid, ticks: rec_q.ticks, pri: rec_q.pri};
              end
            end else if (hc_q == CW'(QUEUE_DEPTH)) begin
              res_d.status = ST_FULL;
            end else begin
              tok0_d.vld   = 1'b1;
              tok0_d.op    = OP_PUSH;
              tok0_d.carry = rec_q;
              tok0_d.pos   = hc_q + CW'(1);
              tok0_d.lvl   = flog2(hc_q + CW'(1));
              hc_d         = hc_q + CW'(1);
              state_d      = S_HWAIT;
            end
          end
          REQ_DEQ: begin
            if (lv_q != 2'd2) begin
              if (f_cnt[lv_q[0]] == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                f_ctl[lv_q[0]].pop = 1'b1;
                state_d = S_FRD;
              end
            end else if (hc_q == '0) begin
              res_d.status = ST_EMPTY;
            end else begin
              tok0_d.vld = 1'b1;
              tok0_d.op  = OP_FETCH;
              tok0_d.pos = PW'(1);
              state_d    = S_HROOT;
            end
          end
          REQ_BOOST: state_d = S_SWEEP;
          default:   res_d = '0;
        endcase
      end
      S_FRD: begin
        res_d.status = ST_OK;
        res_d.pid    = f_rd[lv_q[0]].pid;
        res_d.lvl    = lv_q;
        res_d.ticks  = dec_sat(f_rd[lv_q[0]].ticks);
        res_d.pri    = f_rd[lv_q[0]].pri;
        res_d.clr    = 1'b0;
        state_d      = S_EMIT;
      end
      S_HWAIT: begin
        if (any_done) begin
          state_d = S_EMIT;
        end
      end
      S_HROOT: begin
        if (any_done) begin
          pop_rec_d = resp;
          if (hc_q == CW'(1)) begin
            hc_d    = '0;
            state_d = S_HFIN;
          end else begin
            tok0_d.vld = 1'b1;
            tok0_d.op  = OP_FETCH;
            tok0_d.pos = hc_q;
            tok0_d.lvl = flog2(hc_q);
            state_d    = S_HLAST;
          end
        end
      end
      S_HLAST: begin
        if (any_done) begin
          hc_d         = hc_q - CW'(1);
          tok0_d.vld   = 1'b1;
          tok0_d.op    = OP_SIFT;
          tok0_d.carry = resp;
          tok0_d.pos   = PW'(1);
          tok0_d.cnt   = hc_q - CW'(1);
          state_d      = S_HSIFT;
        end
      end
      S_HSIFT: begin
        if (any_done) begin
          state_d = S_HFIN;
        end
      end
      S_HFIN: begin
        if (req_q == REQ_BOOST) begin
          if (f_cnt[0] == CW'(QUEUE_DEPTH)) begin
            lost_d = 1'b1;
          end else begin
            f_ctl[0].push = 1'b1;
            f_wr[0] = '{pid: pop_rec_q.pid, ticks: TICKS_BOOST, pri: pop_rec_q.pri};
          end
          state_d = S_B1RD;
        end else begin
          res_d.status = ST_OK;
          res_d.pid    = pop_rec_q.pid;
          res_d.lvl    = 2'd2;
          res_d.ticks  = dec_sat(pop_rec_q.ticks);
          res_d.pri    = pop_rec_q.pri;
          res_d.clr    = 1'b0;
          state_d      = S_EMIT;
        end
      end
      S_SWEEP: begin
        if (n_q < f_cnt[0]) begin
          f_ctl[0].tkw = 1'b1;
          n_d = n_q + CW'(1);
        end else begin
          state_d = S_B1RD;
        end
      end
      S_B1RD: begin
        if (f_cnt[1] != '0) begin
          f_ctl[1].pop = 1'b1;
          state_d = S_B1WR;
        end else if (hc_q != '0) begin
          tok0_d.vld = 1'b1;
          tok0_d.op  = OP_FETCH;
          tok0_d.pos = PW'(1);
          state_d    = S_HROOT;
        end else begin
          res_d        = '0;
          res_d.status = lost_q ? ST_FULL : ST_OK;
          res_d.clr    = 1'b1;
          state_d      = S_EMIT;
        end
      end
      S_B1WR: begin
        if (f_cnt[0] == CW'(QUEUE_DEPTH)) begin
          lost_d = 1'b1;
        end else begin
          f_ctl[0].push = 1'b1;
          f_wr[0] = '{pid: f_rd[1].pid, ticks: TICKS_BOOST, pri: f_rd[1].pri};
        end
        state_d = S_B1RD;
      end
      S_EMIT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hc_q      <= '0;
      tok0_q    <= '0;
      m_valid_q <= 1'b0;
      req_q     <= REQ_NONE;
      lv_q      <= '0;
      n_q       <= '0;
      lost_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      hc_q    <= hc_d;
      tok0_q  <= tok0_d;
      req_q   <= req_d;
      lv_q    <= lv_d;
      n_q     <= n_d;
      lost_q  <= lost_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q     <= rec_d;
    pop_rec_q <= pop_rec_d;
    res_q     <= res_d;
    if (load) begin
      m_data_q <= {res_q.pri, res_q.ticks, res_q.lvl, res_q.pid};
      m_user_q <= {res_q.clr, res_q.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   tok_last.vld |-> (tok_last.op == OP_SIFT))
    else $error("Only a sift may leave the last heap level.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !upw_root.vld)
    else $error("Root heap level wrote above itself.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(done_vec))
    else $error("More than one heap level finished at once.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) hc_q <= CW'(QUEUE_DEPTH))
    else $error("Heap count exceeds the depth.");
`endif

endmodule

>>> hw/rtl/mlfq_fifo.sv
// Round-robin FIFO of process records for one scheduler level.
// Depends on mlfq_pkg for the record and control types.
module mlfq_fifo
  import mlfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fifo_ctl_t     ctl_i,
  input  fifo_rec_t     wr_i,
  input  logic [AW-1:0] off_i,
  output fifo_rec_t     rd_o,
  output logic [CW-1:0] cnt_o
);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] tail, tkw_addr;
  logic [9:0]    pp_mem [QUEUE_DEPTH];
  logic [3:0]    tk_mem [QUEUE_DEPTH];
  fifo_rec_t     rd_q;

  function automatic logic [AW-1:0] wrap(logic [AW:0] s);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      return AW'(s - (AW+1)'(QUEUE_DEPTH));
    end
    return AW'(s);
  endfunction

  assign tail     = wrap({1'b0, head_q} + (AW+1)'(cnt_q));
  assign tkw_addr = wrap({1'b0, head_q} + {1'b0, off_i});

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (ctl_i.push) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctl_i.pop) begin
      cnt_d  = cnt_q - CW'(1);
      head_d = wrap({1'b0, head_q} + (AW+1)'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      pp_mem[tail] <= {wr_i.pid, wr_i.pri};
      tk_mem[tail] <= wr_i.ticks;
    end else if (ctl_i.tkw) begin
      tk_mem[tkw_addr] <= TICKS_BOOST;
    end
    if (ctl_i.pop) begin
      rd_q.pid   <= pp_mem[head_q][9:4];
      rd_q.pri   <= pp_mem[head_q][3:0];
      rd_q.ticks <= tk_mem[head_q];
    end
  end

  assign rd_o  = rd_q;
  assign cnt_o = cnt_q;

endmodule

>>> hw/rtl/mlfq_cell.sv
// One level of the level-two min-heap: holds that level's entries and passes
// fetch, push and sift operations down to the next level. Depends on mlfq_pkg.
module mlfq_cell
  import mlfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TICK_BITS   = TICK_BITS_DEF,
  parameter int unsigned K           = 0,
  localparam int unsigned PW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned LW = $clog2(PW),
  localparam int unsigned SZ = ((2 ** K) < (QUEUE_DEPTH + 1 - (2 ** K))) ?
                               (2 ** K) : (QUEUE_DEPTH + 1 - (2 ** K)),
  localparam int unsigned IW = (SZ > 1) ? $clog2(SZ) : 1,
  localparam int unsigned RW = 14 + TICK_BITS,
  localparam int unsigned TW = 1 + 2 + RW + PW + LW + PW + 1,
  localparam int unsigned UW = 1 + PW + RW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [TW-1:0] tok_i,
  output logic [TW-1:0] tok_o,
  input  logic [UW-1:0] upw_i,
  output logic [UW-1:0] upw_o,
  output logic          done_o,
  output logic [RW-1:0] resp_o
);

  typedef struct packed {
    logic [5:0]           pid;
    logic [3:0]           ticks;
    logic [3:0]           pri;
    logic [TICK_BITS-1:0] tk;
  } rec_t;

  typedef struct packed {
    logic          vld;
    op_e           op;
    rec_t          carry;
    logic [PW-1:0] pos;
    logic [LW-1:0] lvl;
    logic [PW-1:0] cnt;
    logic          ins;
  } tok_t;

  typedef struct packed {
    logic          vld;
    logic [PW-1:0] pos;
    rec_t          rec;
  } upw_t;

  localparam logic [PW:0] MASK = (PW+1)'((1 << K) - 1);

  tok_t          tin, tok_q, tok_dn_q, dn_d;
  upw_t          uin, uout;
  rec_t          mem [SZ];
  rec_t          rd_a_q, rd_b_q, best;
  logic [IW-1:0] idx_a, idx_b, idx_a_q;
  logic [PW-1:0] cur_pos;
  logic          own_we, lv_ok, rv_ok, sel_l, sel_r;

  function automatic logic [IW-1:0] idx_of(logic [PW:0] p);
    return IW'(p & MASK);
  endfunction

  function automatic logic after(rec_t a, rec_t b);
    if (a.pri != b.pri) begin
      return a.pri > b.pri;
    end
    return a.tk > b.tk;
  endfunction

  assign tin = tok_i;
  assign uin = upw_i;

  always_comb begin
    cur_pos = tin.pos;
    if (tin.op == OP_PUSH) begin
      cur_pos = tin.pos >> (tin.lvl - LW'(K));
    end
    idx_a = (tin.op == OP_SIFT) ? idx_of({tin.pos, 1'b0}) : idx_of({1'b0, cur_pos});
    idx_b = idx_of({tin.pos, 1'b1});
  end

  always_ff @(posedge clk_i) begin
    if (uin.vld) begin
      mem[idx_of({1'b0, uin.pos})] <= uin.rec;
    end else if (own_we) begin
      mem[idx_a_q] <= tok_q.carry;
    end
    if (tin.vld) begin
      rd_a_q  <= mem[idx_a];
      rd_b_q  <= mem[idx_b];
      idx_a_q <= idx_a;
    end
  end

  always_comb begin
    dn_d     = tok_q;
    dn_d.vld = 1'b0;
    uout     = '0;
    own_we   = 1'b0;
    done_o   = 1'b0;
    resp_o   = '0;
    lv_ok    = {tok_q.pos, 1'b0} <= {1'b0, tok_q.cnt};
    rv_ok    = {tok_q.pos, 1'b1} <= {1'b0, tok_q.cnt};
    sel_l    = lv_ok && after(tok_q.carry, rd_a_q);
    best     = sel_l ? rd_a_q : tok_q.carry;
    sel_r    = rv_ok && after(best, rd_b_q);
    if (tok_q.vld) begin
      case (tok_q.op)
        OP_FETCH: begin
          if (tok_q.lvl == LW'(K)) begin
            done_o = 1'b1;
            resp_o = rd_a_q;
          end else begin
            dn_d.vld = 1'b1;
          end
        end
        OP_PUSH: begin
          if (tok_q.lvl == LW'(K)) begin
            own_we = 1'b1;
            done_o = 1'b1;
          end else begin
            dn_d.vld = 1'b1;
            if (tok_q.ins || after(rd_a_q, tok_q.carry)) begin
              own_we     = 1'b1;
              dn_d.carry = rd_a_q;
              dn_d.ins   = 1'b1;
            end
          end
        end
        OP_SIFT: begin
          if (K == 0) begin
            dn_d.vld = 1'b1;
          end else begin
            uout.vld = 1'b1;
            uout.pos = tok_q.pos;
            if (sel_r) begin
              uout.rec = rd_b_q;
              dn_d.vld = 1'b1;
              dn_d.pos = PW'({tok_q.pos, 1'b1});
            end else if (sel_l) begin
              uout.rec = rd_a_q;
              dn_d.vld = 1'b1;
              dn_d.pos = PW'({tok_q.pos, 1'b0});
            end else begin
              uout.rec = tok_q.carry;
              done_o   = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      tok_dn_q <= '0;
    end else begin
      tok_q    <= tin;
      tok_dn_q <= dn_d;
    end
  end

  assign tok_o = tok_dn_q;
  assign upw_o = uout;

endmodule

>>> tb/sv/tb_mlfq_scheduler_queues.sv
// Testbench for mlfq_scheduler_queues: random and directed scheduler requests
// checked against a behavioral model of the three queue levels held here.
// Depends on mlfq_pkg and the mlfq_scheduler_queues RTL.
`timescale 1ns / 1ps

module tb_mlfq_scheduler_queues;
  import mlfq_pkg::*;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_BOOST = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int DEPTH      = 64;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 300;

  typedef struct {
    req_e        req;
    logic [5:0]  pid;
    logic [1:0]  lv;
    logic [3:0]  tk;
    logic [3:0]  pri;
    logic [31:0] nt;
  } sched_req_t;

  typedef struct {
    logic [5:0]  pid;
    logic [3:0]  tk;
    logic [3:0]  pri;
    logic [31:0] qt;
  } proc_rec_t;

  typedef struct {
    status_e    st;
    logic [5:0] pid;
    logic [1:0] lv;
    logic [3:0] tk;
    logic [3:0] pri;
    logic       clr;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  mlfq_scheduler_queues u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  sched_req_t pending_reqs[$];
  sched_res_t expected_res[$];
  sched_req_t cur_req;
  proc_rec_t  rr_level[2][$];
  proc_rec_t  prio_heap[1:DEPTH];
  int         heap_n = 0;
  bit         beat_taken = 0;
  int         n_in = 0, n_out = 0, n_err = 0, n_boost = 0, n_full = 0, n_empty = 0;
  int         send_gap = 0, recv_gap = 0, recv_hold = 0, stall_cnt = 0;
  bit         pressure_done = 0;

  function automatic bit sits_below(proc_rec_t a, proc_rec_t b);
    if (a.pri != b.pri) return a.pri > b.pri;
    return a.qt > b.qt;
  endfunction

  function automatic void heap_swap(int i, int j);
    proc_rec_t t;
    t = prio_heap[i];
    prio_heap[i] = prio_heap[j];
    prio_heap[j] = t;
  endfunction

  function automatic bit heap_insert(proc_rec_t r);
    int i;
    if (heap_n >= DEPTH) return 0;
    heap_n++;
    i = heap_n;
    prio_heap[i] = r;
    while (i > 1 && sits_below(prio_heap[i / 2], prio_heap[i])) begin
      heap_swap(i / 2, i);
      i = i / 2;
    end
    return 1;
  endfunction

  function automatic bit heap_take(output proc_rec_t r);
    int i, l, s;
    if (heap_n == 0) return 0;
    r = prio_heap[1];
    prio_heap[1] = prio_heap[heap_n];
    heap_n--;
    i = 1;
    forever begin
      l = 2 * i;
      s = i;
      if (l <= heap_n && sits_below(prio_heap[s], prio_heap[l])) s = l;
      if (l + 1 <= heap_n && sits_below(prio_heap[s], prio_heap[l + 1])) s = l + 1;
      if (s == i) break;
      heap_swap(i, s);
      i = s;
    end
    return 1;
  endfunction

  function automatic sched_res_t schedule(sched_req_t q);
    sched_res_t res;
    proc_rec_t  r;
    int         lv;
    bit         ok;
    res = '{ST_OK, 6'd0, 2'd0, 4'd0, 4'd0, 1'b0};
    lv = (q.lv > 2) ? 2 : q.lv;
    case (q.req)
      REQ_ENQ: begin
        r = '{q.pid, q.tk, q.pri, q.nt};
        if (r.tk == 0) begin
          if (lv < 2) lv++;
          else if (r.pri > 0) r.pri--;
          r.tk = 4'(2 * lv + 4);
        end
        if (lv == 2) ok = heap_insert(r);
        else begin
          ok = rr_level[lv].size() < DEPTH;
          if (ok) rr_level[lv].push_back(r);
        end
        res = '{ok ? ST_OK : ST_FULL, r.pid, lv[1:0], r.tk, r.pri, 1'b0};
      end
      REQ_DEQ: begin
        if (lv == 2) ok = heap_take(r);
        else begin
          ok = rr_level[lv].size() > 0;
          if (ok) r = rr_level[lv].pop_front();
        end
        if (!ok) res.st = ST_EMPTY;
        else begin
          if (r.tk > 0) r.tk--;
          res = '{ST_OK, r.pid, lv[1:0], r.tk, r.pri, 1'b0};
        end
      end
      REQ_BOOST: begin
        ok = 1;
        foreach (rr_level[0][i]) rr_level[0][i].tk = TICKS_BOOST;
        while (rr_level[1].size() > 0) begin
          r = rr_level[1].pop_front();
          r.tk = TICKS_BOOST;
          if (rr_level[0].size() < DEPTH) rr_level[0].push_back(r);
          else ok = 0;
        end
        while (heap_take(r)) begin
          r.tk = TICKS_BOOST;
          if (rr_level[0].size() < DEPTH) rr_level[0].push_back(r);
          else ok = 0;
        end
        res.st = ok ? ST_OK : ST_FULL;
        res.clr = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_req(req_e rq, int pid, int lv, int tk, int pri, logic [31:0] nt);
    sched_req_t q;
    q = '{rq, pid[5:0], lv[1:0], tk[3:0], pri[3:0], nt};
    pending_reqs.push_back(q);
  endfunction

  function automatic void add_random_req();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 52)
      add_req(REQ_ENQ, $urandom_range(0, 63), $urandom_range(0, 3),
              ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15),
              $urandom_range(0, 15), ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7)));
    else if (sel < 92)
      add_req(REQ_DEQ, $urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom);
    else if (sel < 97)
      add_req(REQ_BOOST, $urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom);
    else
      add_req(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom);
  endfunction

  // Driver: offers queued requests, holding each beat until it is taken.
  always @(negedge clk_i) begin
    logic       nv;
    sched_req_t q;
    nv = 1'b0;
    q = cur_req;
    if (rst_ni) begin
      if (s_axis_tvalid && !beat_taken) begin
        nv = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() > 60 && $urandom_range(0, 6) == 0) begin
        send_gap = $urandom_range(1, 8);
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        nv = 1'b1;
      end
    end
    beat_taken = 0;
    cur_req = q;
    s_axis_tvalid <= nv;
    s_axis_tdata  <= {q.nt, q.pri, q.tk, q.lv, q.pid};
    s_axis_tuser  <= q.req;
  end

  // Receiver: random back-pressure plus one long hold-off.
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (!pressure_done && n_in >= 150) begin
      pressure_done = 1;
      recv_hold = 500;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      rdy = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rdy = 1'b0;
    end else if (pending_reqs.size() > 60 && $urandom_range(0, 6) == 0) begin
      recv_gap = $urandom_range(1, 8);
      rdy = 1'b0;
    end
    m_axis_tready <= rst_ni ? rdy : 1'b0;
  end

  // Input side: predict each accepted request.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      beat_taken = 1;
      n_in++;
      expected_res.push_back(schedule(cur_req));
    end
  end

  // Output side: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    sched_res_t e;
    sched_res_t a;
    if (m_axis_tvalid && m_axis_tready) begin
      n_out++;
      a.st  = status_e'(m_axis_tuser[1:0]);
      a.clr = m_axis_tuser[2];
      a.pid = m_axis_tdata[5:0];
      a.lv  = m_axis_tdata[7:6];
      a.tk  = m_axis_tdata[11:8];
      a.pri = m_axis_tdata[15:12];
      if (expected_res.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected result beat %p", a);
      end else begin
        e = expected_res.pop_front();
        if (a.clr) n_boost++;
        if (a.st == ST_FULL) n_full++;
        if (a.st == ST_EMPTY) n_empty++;
        if (a.st != e.st || a.pid != e.pid || a.lv != e.lv || a.tk != e.tk ||
            a.pri != e.pri || a.clr != e.clr) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: result %0d expected %p actual %p", n_out, e, a);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("mlfq_scheduler_queues test failed");
      $finish;
    end
  end

  initial begin
    // Directed: empty levels, extremes, demotion on every level, unused request.
    add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    add_req(REQ_DEQ, 63, 1, 15, 15, 32'hFFFF_FFFF);
    add_req(REQ_DEQ, 0, 2, 0, 0, 0);
    add_req(REQ_DEQ, 0, 3, 0, 0, 0);
    add_req(REQ_ENQ, 63, 0, 15, 15, 32'hFFFF_FFFF);
    add_req(REQ_ENQ, 0, 0, 0, 0, 0);
    add_req(REQ_ENQ, 21, 1, 0, 7, 5);
    add_req(REQ_ENQ, 42, 2, 0, 0, 9);
    add_req(REQ_ENQ, 10, 2, 0, 15, 3);
    add_req(REQ_ENQ, 11, 3, 8, 4, 2);
    add_req(REQ_ENQ, 12, 2, 8, 4, 1);
    add_req(REQ_ENQ, 13, 2, 9, 4, 1);
    add_req(REQ_NONE, 63, 3, 15, 15, 32'hFFFF_FFFF);
    add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    add_req(REQ_DEQ, 0, 2, 0, 0, 0);
    add_req(REQ_DEQ, 0, 3, 0, 0, 0);
    add_req(REQ_BOOST, 0, 0, 0, 0, 0);
    add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    add_req(REQ_ENQ, 5, 0, 1, 2, 0);
    add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    add_req(REQ_ENQ, 6, 0, 1, 2, 0);
    add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    // Fill levels 0 and 2 past their depth, then boost into an overfull level 0.
    for (int i = 0; i < DEPTH + 2; i++)
      add_req(REQ_ENQ, i, 0, $urandom_range(1, 8), $urandom_range(0, 15), $urandom);
    for (int i = 0; i < DEPTH + 2; i++)
      add_req(REQ_ENQ, i, 2, $urandom_range(1, 8), $urandom_range(0, 3), $urandom_range(0, 3));
    add_req(REQ_ENQ, 1, 1, 3, 3, 3);
    add_req(REQ_BOOST, 0, 0, 0, 0, 0);
    for (int i = 0; i < 30; i++) add_req(REQ_DEQ, 0, 0, 0, 0, 0);
    for (int i = 0; i < 310; i++) add_random_req();
    repeat (4) @(posedge clk_i);
    rst_ni = 1'b1;
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_res.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Run covered %0d requests and %0d results: %0d boosts, %0d full, %0d empty.",
             n_in, n_out, n_boost, n_full, n_empty);
    if (n_err == 0 && expected_res.size() == 0) begin
      $display("mlfq_scheduler_queues test passed");
    end else begin
      $display("Mismatches: %0d", n_err);
      $display("mlfq_scheduler_queues test failed");
    end
    $finish;
  end

endmodule
